[rtl/thc_pkg.sv]
// Shared types, codes and digit arithmetic for the twelve-hour clock.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package thc_pkg;

  // Field widths.
  localparam int unsigned TpsW    = 10;
  localparam int unsigned HourW   = 4;
  localparam int unsigned MinW    = 6;
  localparam int unsigned CursorW = 4;

  localparam logic [TpsW-1:0]    TpsReset  = 10'd100;
  localparam logic [HourW-1:0]   HourTop   = 4'd12;
  localparam logic [MinW-1:0]    MinTop    = 6'd59;
  localparam logic [CursorW-1:0] CursorMax = 4'd10;

  // Request types.
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_KEY  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // Keypad codes above the digits.
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_RIGHT     = 4'd10;
  localparam logic [3:0] KEY_LEFT      = 4'd11;
  localparam logic [3:0] KEY_RESET     = 4'd12;
  localparam logic [3:0] KEY_DONE      = 4'd13;
  localparam logic [3:0] KEY_AMPM      = 4'd14;

  // Cursor positions over "HH:MM:SS Xm".
  localparam logic [CursorW-1:0] POS_HOUR_T = 4'd0;
  localparam logic [CursorW-1:0] POS_HOUR_O = 4'd1;
  localparam logic [CursorW-1:0] POS_SEP_H  = 4'd2;
  localparam logic [CursorW-1:0] POS_MIN_T  = 4'd3;
  localparam logic [CursorW-1:0] POS_MIN_O  = 4'd4;
  localparam logic [CursorW-1:0] POS_SEP_M  = 4'd5;
  localparam logic [CursorW-1:0] POS_SEC_T  = 4'd6;
  localparam logic [CursorW-1:0] POS_SEC_O  = 4'd7;
  localparam logic [CursorW-1:0] POS_SEP_S  = 4'd8;

  // One input word.
  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_code;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [HourW-1:0]   hours_out;
    logic [MinW-1:0]    minutes_out;
    logic [MinW-1:0]    seconds_out;
    logic               is_pm;
    logic               in_set_mode;
    logic [CursorW-1:0] cursor_out;
    logic               second_elapsed;
  } out_word_t;

  // Replace the tens or the ones digit of a value below 100.
  function automatic logic [6:0] digit_edit(input logic [6:0] value,
                                            input logic [3:0] digit,
                                            input logic       tens);
    logic [3:0] t;
    logic [6:0] ones;
    t = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (value >= 7'(10 * i)) t = t + 4'd1;
    end
    ones = value - 7'(t) * 7'd10;
    if (tens) begin
      return ones + 7'(digit) * 7'd10;
    end
    return value - ones + 7'(digit);
  endfunction

  // Fold an edited hour into 1 to 12; zero stays zero.
  function automatic logic [HourW-1:0] hour_wrap(input logic [6:0] value);
    logic [3:0] k;
    logic [6:0] r;
    k = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (value >= 7'(13 + 12 * i)) k = k + 4'd1;
    end
    r = value - 7'(k) * 7'd12;
    return r[HourW-1:0];
  endfunction

  // Minutes and seconds below 100 reduced modulo 60.
  function automatic logic [MinW-1:0] wrap60(input logic [6:0] value);
    logic [6:0] r;
    r = (value >= 7'd60) ? value - 7'd60 : value;
    return r[MinW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/thc_in_stage.sv]
// Input register of the clock: captures one request word and holds it
// until the result register can take its outcome. Uses thc_pkg.
`default_nettype none

module thc_in_stage
  import thc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  input  wire logic     fwd_ready,
  output logic          held_valid,
  output in_word_t      held_word
);

  logic take;

  // A held word that cannot move on blocks the next one.
  assign in_stall = held_valid && !fwd_ready;
  assign take     = in_valid && !in_stall;

  // Valid flag and payload of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (fwd_ready) begin
      held_valid <= 1'b0;
    end
    if (take) begin
      held_word <= in_word;
    end
  end

endmodule

`default_nettype wire

[rtl/thc_time_core.sv]
// Time-keeping state and its combinational update for one request word.
// Holds the prescaler, time, AM/PM, set mode, cursor and ticks_per_second. Uses thc_pkg.
`default_nettype none

module thc_time_core
  import thc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  input  wire logic [TpsW-1:0] cfg_data,
  input  wire logic            step,
  input  wire in_word_t        word,
  output out_word_t            result
);

  logic [TpsW-1:0]    ticks_per_second;
  logic [TpsW-1:0]    tick_prescale, tick_prescale_next;
  logic [MinW-1:0]    sec_count, sec_count_next;
  logic [MinW-1:0]    min_count, min_count_next;
  logic [HourW-1:0]   hour_count, hour_count_next;
  logic               pm_flag, pm_flag_next;
  logic               set_mode, set_mode_next;
  logic [CursorW-1:0] cursor_pos, cursor_pos_next;
  logic               elapsed;

  logic [TpsW:0]      pre_inc;
  logic [HourW:0]     hour_inc;
  logic               tens_pos;
  logic [3:0]         key;

  assign key      = word.key_code;
  assign pre_inc  = {1'b0, tick_prescale} + {{TpsW{1'b0}}, 1'b1};
  assign hour_inc = {1'b0, hour_count} + {{HourW{1'b0}}, 1'b1};
  assign tens_pos = (cursor_pos == POS_HOUR_T) || (cursor_pos == POS_MIN_T) ||
                    (cursor_pos == POS_SEC_T);

  // Next state for the word in the input register.
  always_comb begin
    tick_prescale_next = tick_prescale;
    sec_count_next     = sec_count;
    min_count_next     = min_count;
    hour_count_next    = hour_count;
    pm_flag_next       = pm_flag;
    set_mode_next      = set_mode;
    cursor_pos_next    = cursor_pos;
    elapsed            = 1'b0;

    case (req_t'(word.req_type))
      REQ_TICK: begin
        if (!set_mode) begin
          if (pre_inc >= {1'b0, ticks_per_second}) begin
            tick_prescale_next = '0;
            elapsed            = 1'b1;
            // Carry through seconds, minutes and hours.
            if (sec_count >= MinTop) begin
              sec_count_next = '0;
              if (min_count >= MinTop) begin
                min_count_next = '0;
                if (hour_inc > {1'b0, HourTop}) begin
                  hour_count_next = 4'd1;
                end else begin
                  hour_count_next = hour_inc[HourW-1:0];
                  if (hour_inc == {1'b0, HourTop}) pm_flag_next = !pm_flag;
                end
              end else begin
                min_count_next = min_count + 6'd1;
              end
            end else begin
              sec_count_next = sec_count + 6'd1;
            end
          end else begin
            tick_prescale_next = pre_inc[TpsW-1:0];
          end
        end
      end
      REQ_SET: begin
        if (!set_mode) begin
          set_mode_next   = 1'b1;
          cursor_pos_next = '0;
        end
      end
      REQ_KEY: begin
        if (set_mode) begin
          if (key <= KEY_DIGIT_MAX) begin
            // Digit entry at the cursor, then the cursor steps right.
            if (cursor_pos == POS_HOUR_T || cursor_pos == POS_HOUR_O) begin
              hour_count_next = hour_wrap(digit_edit({3'b000, hour_count},
                                                     key, tens_pos));
              cursor_pos_next = cursor_pos + 4'd1;
            end else if (cursor_pos == POS_MIN_T || cursor_pos == POS_MIN_O) begin
              min_count_next  = wrap60(digit_edit({1'b0, min_count}, key, tens_pos));
              cursor_pos_next = cursor_pos + 4'd1;
            end else if (cursor_pos == POS_SEC_T || cursor_pos == POS_SEC_O) begin
              sec_count_next  = wrap60(digit_edit({1'b0, sec_count}, key, tens_pos));
              cursor_pos_next = cursor_pos + 4'd1;
            end else if (cursor_pos == POS_SEP_H || cursor_pos == POS_SEP_M ||
                         cursor_pos == POS_SEP_S) begin
              cursor_pos_next = cursor_pos + 4'd1;
            end
          end else if (key == KEY_RIGHT) begin
            if (cursor_pos < CursorMax) cursor_pos_next = cursor_pos + 4'd1;
          end else if (key == KEY_LEFT) begin
            if (cursor_pos != '0) cursor_pos_next = cursor_pos - 4'd1;
          end else if (key == KEY_RESET) begin
            hour_count_next = HourTop;
            min_count_next  = '0;
            sec_count_next  = '0;
            pm_flag_next    = 1'b0;
            set_mode_next   = 1'b0;
            cursor_pos_next = '0;
          end else if (key == KEY_DONE) begin
            set_mode_next   = 1'b0;
            cursor_pos_next = '0;
          end else if (key == KEY_AMPM) begin
            pm_flag_next = !pm_flag;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // The result shows the state after this word.
  always_comb begin
    result.hours_out      = hour_count_next;
    result.minutes_out    = min_count_next;
    result.seconds_out    = sec_count_next;
    result.is_pm          = pm_flag_next;
    result.in_set_mode    = set_mode_next;
    result.cursor_out     = cursor_pos_next;
    result.second_elapsed = elapsed;
  end

  // State registers and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TpsReset;
      tick_prescale    <= '0;
      sec_count        <= '0;
      min_count        <= '0;
      hour_count       <= HourTop;
      pm_flag          <= 1'b0;
      set_mode         <= 1'b0;
      cursor_pos       <= '0;
    end else begin
      if (cfg_valid) begin
        ticks_per_second <= cfg_data;
      end
      if (step) begin
        tick_prescale <= tick_prescale_next;
        sec_count     <= sec_count_next;
        min_count     <= min_count_next;
        hour_count    <= hour_count_next;
        pm_flag       <= pm_flag_next;
        set_mode      <= set_mode_next;
        cursor_pos    <= cursor_pos_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/thc_out_stage.sv]
// Result register of the clock: holds one result word until the
// downstream side takes it. Uses thc_pkg.
`default_nettype none

module thc_out_stage
  import thc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_word_t load_word,
  output logic           ready,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  // Room for a new word when empty or when the held word leaves now.
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_word <= load_word;
    end
  end

endmodule

`default_nettype wire

[rtl/twelve_hour_clock_with_keypad_set.sv]
// Twelve-hour clock with keypad time setting: top level.
// An accepted word waits in the input register, then its result word is registered.
// Throughput: one word per cycle while the result side does not stall, set by the
// combinational state update between the input register and the result register.
// Reset (rst, synchronous): 12:00:00 am, running, cursor 0, prescaler 0,
// ticks_per_second 100, both registers empty. Uses thc_pkg and submodules.
`default_nettype none

module twelve_hour_clock_with_keypad_set
  import thc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_word_t        in_word,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_word_t            out_word,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [TpsW-1:0] cfg_data
);

  logic      held_valid;
  in_word_t  held_word;
  logic      fwd_ready;
  logic      step;
  out_word_t result;

  // The configuration register is always writable.
  assign cfg_ready = 1'b1;

  // A held word is processed when the result register has room.
  assign step = held_valid && fwd_ready;

  thc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .fwd_ready  (fwd_ready),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  thc_time_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .step      (step),
    .word      (held_word),
    .result    (result)
  );

  thc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .load_word (result),
    .ready     (fwd_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

[rtl/thc_checker.sv]
// Port-level checks for the twelve-hour clock, bound to the top level.
// Uses thc_pkg for the word types and limits.
`default_nettype none

module thc_checker
  import thc_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire out_word_t       out_word
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present straight after reset");

  // A second only elapses while the clock runs.
  a_elapsed_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.second_elapsed |-> !out_word.in_set_mode)
    else $error("second elapsed in set mode");

  // Outside set mode the cursor rests at the first position.
  a_cursor_home: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.in_set_mode |-> out_word.cursor_out == '0)
    else $error("cursor away from home while running");

  // Time fields and cursor stay within range.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.minutes_out <= MinTop && out_word.seconds_out <= MinTop &&
                  out_word.hours_out <= HourTop && out_word.cursor_out <= CursorMax)
    else $error("result field out of range");

endmodule

bind twelve_hour_clock_with_keypad_set thc_checker u_thc_checker (.*);

`default_nettype wire

[bench/clock_face_checker.sv]
`timescale 1ns / 100ps
// Checker for the twelve-hour clock: keeps its own copy of the clock state,
// predicts every result word from the accepted input words and register
// writes, and compares them in order. Depends on thc_pkg for types and codes.

module clock_face_checker
  import thc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_stall,
  input  wire in_word_t        in_word,
  input  wire logic            out_valid,
  input  wire logic            out_stall,
  input  wire out_word_t       out_word,
  input  wire logic            cfg_valid,
  input  wire logic            cfg_ready,
  input  wire logic [TpsW-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   words_checked,
  output int                   seconds_seen
);

  localparam int HourLast  = HourTop;
  localparam int MinLast   = MinTop;
  localparam int SixtyWrap = 60;

  // Predicted clock state and the one register.
  int   tps;
  int   prescale;
  int   secs;
  int   mins;
  int   hrs;
  int   cursor;
  logic pm;
  logic editing;

  // Result words still to arrive, oldest first.
  out_word_t predicted_faces[$];

  // Replace the tens or the ones digit of a two-digit value.
  function automatic int set_digit(int value, int digit, bit tens);
    if (tens) begin
      return (value % 10) + 10 * digit;
    end
    return value - (value % 10) + digit;
  endfunction

  // Print one line per failure and count every one.
  task automatic note_failure(string msg);
    $display("[%0t] MISMATCH word %0d: %s", $time, words_checked, msg);
    fail_count++;
  endtask

  // Apply one input word to the predicted state and form its result word.
  task automatic predict_face(input in_word_t w, output out_word_t face);
    int   nxt;
    int   v;
    int   d;
    bit   tens;
    logic elapsed;
    elapsed = 1'b0;
    d = w.key_code;
    case (w.req_type)
      REQ_TICK: begin
        // Ticks only count while running; the prescaler holds in set mode.
        if (!editing) begin
          nxt = prescale + 1;
          if (nxt >= tps) begin
            prescale = 0;
            elapsed = 1'b1;
            secs++;
            if (secs > MinLast) begin
              secs = 0;
              mins++;
              if (mins > MinLast) begin
                mins = 0;
                hrs++;
                if (hrs > HourLast) begin
                  hrs = 1;
                end else if (hrs == HourLast) begin
                  pm = ~pm;
                end
              end
            end
          end else begin
            prescale = nxt;
          end
        end
      end
      REQ_SET: begin
        if (!editing) begin
          editing = 1'b1;
          cursor = 0;
        end
      end
      REQ_KEY: begin
        if (editing && w.key_code <= KEY_DIGIT_MAX) begin
          // Tens digits sit at every third position of the layout.
          tens = (cursor % 3) == 0;
          if (cursor <= int'(POS_HOUR_O)) begin
            v = set_digit(hrs, d, tens);
            hrs = (v == 0) ? 0 : ((v - 1) % HourLast) + 1;
            cursor++;
          end else if (cursor == int'(POS_MIN_T) || cursor == int'(POS_MIN_O)) begin
            mins = set_digit(mins, d, tens) % SixtyWrap;
            cursor++;
          end else if (cursor == int'(POS_SEC_T) || cursor == int'(POS_SEC_O)) begin
            secs = set_digit(secs, d, tens) % SixtyWrap;
            cursor++;
          end else if (cursor == int'(POS_SEP_H) || cursor == int'(POS_SEP_M) ||
                       cursor == int'(POS_SEP_S)) begin
            cursor++;
          end
        end else if (editing) begin
          case (w.key_code)
            KEY_RIGHT: if (cursor < int'(CursorMax)) cursor++;
            KEY_LEFT:  if (cursor != 0) cursor--;
            KEY_RESET: begin
              hrs = HourLast;
              mins = 0;
              secs = 0;
              pm = 1'b0;
              editing = 1'b0;
              cursor = 0;
            end
            KEY_DONE: begin
              editing = 1'b0;
              cursor = 0;
            end
            KEY_AMPM: pm = ~pm;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    face.hours_out      = HourW'(hrs);
    face.minutes_out    = MinW'(mins);
    face.seconds_out    = MinW'(secs);
    face.is_pm          = pm;
    face.in_set_mode    = editing;
    face.cursor_out     = CursorW'(cursor);
    face.second_elapsed = elapsed;
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    out_word_t want;
    out_word_t face;
    if (rst) begin
      tps = TpsReset;
      prescale = 0;
      secs = 0;
      mins = 0;
      hrs = HourLast;
      cursor = 0;
      pm = 1'b0;
      editing = 1'b0;
      predicted_faces.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        tps = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (predicted_faces.size() == 0) begin
          note_failure("result word with nothing expected");
        end else begin
          want = predicted_faces.pop_front();
          if (out_word.hours_out !== want.hours_out)
            note_failure($sformatf("hours %0d, expected %0d",
                                   out_word.hours_out, want.hours_out));
          if (out_word.minutes_out !== want.minutes_out)
            note_failure($sformatf("minutes %0d, expected %0d",
                                   out_word.minutes_out, want.minutes_out));
          if (out_word.seconds_out !== want.seconds_out)
            note_failure($sformatf("seconds %0d, expected %0d",
                                   out_word.seconds_out, want.seconds_out));
          if (out_word.is_pm !== want.is_pm)
            note_failure($sformatf("pm flag %0b, expected %0b",
                                   out_word.is_pm, want.is_pm));
          if (out_word.in_set_mode !== want.in_set_mode)
            note_failure($sformatf("set mode %0b, expected %0b",
                                   out_word.in_set_mode, want.in_set_mode));
          if (out_word.cursor_out !== want.cursor_out)
            note_failure($sformatf("cursor %0d, expected %0d",
                                   out_word.cursor_out, want.cursor_out));
          if (out_word.second_elapsed !== want.second_elapsed)
            note_failure($sformatf("second elapsed %0b, expected %0b",
                                   out_word.second_elapsed, want.second_elapsed));
          words_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        predict_face(in_word, face);
        predicted_faces.push_back(face);
        if (face.second_elapsed) begin
          seconds_seen++;
        end
      end
    end
    pending = predicted_faces.size();
  end

endmodule

[bench/twelve_hour_clock_with_keypad_set_test.sv]
`timescale 1ns / 100ps
// Top of the twelve-hour clock testbench: clock, reset, stimulus, stalls and
// the verdict. Depends on thc_pkg, the block itself and clock_face_checker.

module twelve_hour_clock_with_keypad_set_test;
  import thc_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int PhaseWords   = 225;
  localparam int HoldOffLen   = 80;
  localparam logic [3:0] KeyNone = 4'd15;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_word_t        in_word = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_word_t       out_word;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [TpsW-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int words_checked;
  int seconds_seen;

  int   tx_pct = 0;
  int   rx_pct = 0;
  int   words_offered = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;

  twelve_hour_clock_with_keypad_set u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  clock_face_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .seconds_seen  (seconds_seen)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d words outstanding.",
               cycle_count, pending);
      $display("twelve_hour_clock_with_keypad_set verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HoldOffLen;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  // Offer one word, with random sender gaps, and wait until it is taken.
  task automatic offer_word(input logic [1:0] req, input logic [3:0] key);
    in_word_t w;
    w.req_type = req;
    w.key_code = key;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_offered++;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_tps(input logic [TpsW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random stretch: mostly a full edit followed by ticks, else plain
  // ticks or random noise.
  task automatic play_sequence();
    int kind;
    int n;
    int d;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      offer_word(REQ_SET, 4'($urandom));
      for (int pos = 0; pos < 9; pos++) begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 4))
            0: offer_word(REQ_KEY, KEY_LEFT);
            1: offer_word(REQ_KEY, KEY_RIGHT);
            2: offer_word(REQ_KEY, KEY_AMPM);
            3: offer_word(REQ_KEY, KeyNone);
            default: offer_word(REQ_TICK, 4'($urandom));
          endcase
        end
        // Lean towards times just short of a rollover.
        d = $urandom_range(0, 9);
        if ((pos == 3 || pos == 6) && $urandom_range(0, 1)) d = 5;
        if (pos == 4 && $urandom_range(0, 1)) d = 9;
        if (pos == 0 && $urandom_range(0, 2) != 0) d = $urandom_range(0, 1);
        offer_word(REQ_KEY, 4'(d));
      end
      if ($urandom_range(0, 3) == 0) offer_word(REQ_KEY, 4'($urandom_range(0, 9)));
      if ($urandom_range(0, 1)) offer_word(REQ_KEY, KEY_AMPM);
      offer_word(REQ_KEY, ($urandom_range(0, 7) == 0) ? KEY_RESET : KEY_DONE);
      n = $urandom_range(1, 40);
      repeat (n) offer_word(REQ_TICK, 4'($urandom));
    end else if (kind < 8) begin
      n = $urandom_range(1, 60);
      repeat (n) offer_word(REQ_TICK, 4'($urandom));
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) offer_word(2'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    int tps_plan[8];
    int target;
    tps_plan = '{1023, 3, 1, 0, 2, 59, 1, 5};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: one tick per second so that rollovers come quickly.
    write_tps(1);
    offer_word(REQ_NONE, KeyNone);      // unused request type
    offer_word(REQ_KEY, 4'd5);          // key while running is ignored
    offer_word(REQ_TICK, 4'd0);         // 12:00:01
    offer_word(REQ_SET, 4'd0);
    offer_word(REQ_SET, 4'd0);          // second press while editing
    offer_word(REQ_TICK, 4'd0);         // ticks held off while editing
    offer_word(REQ_KEY, KeyNone);
    offer_word(REQ_KEY, KEY_LEFT);      // cursor already at the left end
    offer_word(REQ_KEY, 4'd0);          // hour tens: 12 becomes 2
    offer_word(REQ_KEY, 4'd0);          // hour ones: 2 becomes 0
    offer_word(REQ_KEY, 4'd9);          // digit on a separator
    offer_word(REQ_KEY, 4'd9);          // minutes 90 fold to 30
    offer_word(REQ_KEY, KEY_LEFT);
    offer_word(REQ_KEY, 4'd5);
    offer_word(REQ_KEY, 4'd9);          // minutes 59
    offer_word(REQ_KEY, 4'd8);
    offer_word(REQ_KEY, 4'd5);
    offer_word(REQ_KEY, 4'd9);          // seconds 59
    offer_word(REQ_KEY, 4'd1);
    offer_word(REQ_KEY, 4'd3);          // digit past the seconds does nothing
    offer_word(REQ_KEY, KEY_RIGHT);
    offer_word(REQ_KEY, KEY_RIGHT);     // cursor held at the right end
    offer_word(REQ_KEY, KEY_AMPM);
    offer_word(REQ_KEY, KEY_DONE);
    offer_word(REQ_TICK, 4'd0);         // hour advances from zero, no toggle
    offer_word(REQ_SET, 4'd0);
    offer_word(REQ_KEY, KEY_RESET);

    // Random part: eight register settings, cycling through the idle modes.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_tps(tps_plan[ph][TpsW-1:0]);
      case (ph % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 55; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 55; end
        default: begin tx_pct = 11; rx_pct = 11; end
      endcase
      // Long hold-off on the result side while words keep coming.
      if (ph == 4) hold_toggle = ~hold_toggle;
      target = words_offered + PhaseWords;
      while (words_offered < target) play_sequence();
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Ran %0d input words through eight prescaler settings, edits and idle modes;",
             words_offered);
    $display("%0d result words compared, %0d of them advanced the seconds.",
             words_checked, seconds_seen);
    if (fail_count == 0) begin
      $display("twelve_hour_clock_with_keypad_set verification clean");
    end else begin
      $display("twelve_hour_clock_with_keypad_set verification failed");
    end
    $finish;
  end

endmodule
